@@ design/tmmg_pkg.sv @@
package tmmg_pkg;

   // default table depth
   localparam int MAX_POINTS_DEF = 32;

   // field widths
   localparam int ID_W       = 32;
   localparam int COORD_W    = 16;
   localparam int ENTRY_W    = ID_W + 2 * COORD_W;
   localparam int IDX_W      = 6;
   localparam int CSR_DATA_W = 16;
   localparam int REQ_DATA_W = 64;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 24;

   // distance datapath widths
   localparam int SQ_W       = 34;
   localparam int RAD_W      = SQ_W + 2;
   localparam int ROOT_W     = RAD_W / 2;
   localparam int REM_W      = ROOT_W + 2;
   localparam int ROOT_STEPS = ROOT_W;
   localparam int STEP_W     = $clog2(ROOT_STEPS);
   localparam int SUM_W      = 23;
   localparam int MUL_W      = 16;
   localparam int PROD_W     = 2 * MUL_W;

   // action codes
   typedef enum logic [REQ_USER_W-1:0] {
      ACT_LOAD_PREV = 2'd0,
      ACT_LOAD_CURR = 2'd1,
      ACT_RUN       = 2'd2,
      ACT_NONE      = 2'd3
   } action_type;

   // run sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREV_RD,
      ST_CURR_RD,
      ST_CMP,
      ST_SQ_X,
      ST_SQ_Y,
      ST_ROOT,
      ST_ACC,
      ST_PROD,
      ST_SUMMARY
   } state_type;

endpackage

@@ design/track_match_motion_gate.sv @@
// load words (previous or current entry) are taken one per cycle while idle, no result
// run word: each previous entry is read, then current entries are read and compared in
//   turn until the scan finds an id not below it or runs past the last current entry;
//   a match takes two squares on the shared multiplier, 18 root steps and an accumulate,
//   and the run closes with product and summary; a held result word stalls the sequencer
// reset clears fill counts, min_radius, sequencer and output valid; tables undefined
module track_match_motion_gate #(
   parameter int MAX_POINTS = tmmg_pkg::MAX_POINTS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // csr: min_radius
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [tmmg_pkg::CSR_DATA_W-1:0] csr_data,
   // tdata: point_id[31:0], pos_x[47:32], pos_y[63:48]
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [tmmg_pkg::REQ_DATA_W-1:0] req_tdata,
   // tuser: action[1:0]
   input  logic [tmmg_pkg::REQ_USER_W-1:0] req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // tdata: prev_index[5:0], curr_index[11:6], match_count[17:12], skip[18], zero
   output logic [tmmg_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // tuser: is_match
   output logic                            rsp_tuser,
   output logic                            rsp_tlast
);
   import tmmg_pkg::*;

   localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CW = $clog2(MAX_POINTS + 1);

   // tables
   logic [ENTRY_W-1:0] prev_mem [MAX_POINTS];
   logic [ENTRY_W-1:0] curr_mem [MAX_POINTS];

   state_type state_ff, state_in;

   logic [CSR_DATA_W-1:0] min_radius_ff;
   logic [CW-1:0]         prev_fill_ff, curr_fill_ff;
   logic [CW-1:0]         i_ff, j_ff, count_ff;
   logic [ENTRY_W-1:0]    prev_rd_ff, curr_rd_ff;
   logic [SUM_W-1:0]      sum_ff;
   logic [SQ_W-1:0]       sq_ff;
   logic [RAD_W-1:0]      rad_ff;
   logic [REM_W-1:0]      rem_ff;
   logic [ROOT_W-1:0]     root_ff;
   logic [STEP_W-1:0]     step_ff;
   logic [PROD_W-1:0]     prod_ff;
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic                  rsp_user_ff, rsp_last_ff;

   // control
   logic req_acc, out_free, prev_more, curr_more;
   logic id_gt, id_eq;
   logic run_start, load_prev, load_curr;
   logic prev_rd_en, curr_rd_en, i_inc, j_inc;
   logic emit_match, emit_summary, sq_first, sq_second, root_step, acc_en, prod_en;

   // datapath
   action_type              action;
   logic signed [COORD_W:0] dx, dy;
   logic [MUL_W-1:0]        abs_dx, abs_dy, mul_a, mul_b;
   logic [PROD_W-1:0]       mul_p;
   logic [SQ_W-1:0]         sq_sum;
   logic [REM_W-1:0]        rem_shift, trial;
   logic                    trial_ok;
   logic [ROOT_W:0]         root_inc;
   logic                    skip;

   assign action     = action_type'(req_tuser);
   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign prev_more  = (i_ff < prev_fill_ff);
   assign curr_more  = (j_ff < curr_fill_ff);
   assign id_gt      = (prev_rd_ff[ENTRY_W-1 -: ID_W] > curr_rd_ff[ENTRY_W-1 -: ID_W]);
   assign id_eq      = (prev_rd_ff[ENTRY_W-1 -: ID_W] == curr_rd_ff[ENTRY_W-1 -: ID_W]);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc && action == ACT_RUN) state_in = ST_PREV_RD;
         end
         ST_PREV_RD: state_in = prev_more ? ST_CURR_RD : ST_PROD;
         ST_CURR_RD: state_in = curr_more ? ST_CMP : ST_PREV_RD;
         ST_CMP: begin
            if (id_gt) state_in = ST_CURR_RD;
            else if (!id_eq) state_in = ST_PREV_RD;
            else if (out_free) state_in = ST_SQ_X;
         end
         ST_SQ_X:  state_in = ST_SQ_Y;
         ST_SQ_Y:  state_in = ST_ROOT;
         ST_ROOT: begin
            if (step_ff == STEP_W'(ROOT_STEPS - 1)) state_in = ST_ACC;
         end
         ST_ACC:   state_in = ST_PREV_RD;
         ST_PROD:  state_in = ST_SUMMARY;
         ST_SUMMARY: begin
            if (out_free) state_in = ST_IDLE;
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      run_start    = 1'b0;
      load_prev    = 1'b0;
      load_curr    = 1'b0;
      prev_rd_en   = 1'b0;
      curr_rd_en   = 1'b0;
      i_inc        = 1'b0;
      j_inc        = 1'b0;
      emit_match   = 1'b0;
      emit_summary = 1'b0;
      sq_first     = 1'b0;
      sq_second    = 1'b0;
      root_step    = 1'b0;
      acc_en       = 1'b0;
      prod_en      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            run_start = req_acc && (action == ACT_RUN);
            load_prev = req_acc && (action == ACT_LOAD_PREV) &&
                        (prev_fill_ff < CW'(MAX_POINTS));
            load_curr = req_acc && (action == ACT_LOAD_CURR) &&
                        (curr_fill_ff < CW'(MAX_POINTS));
         end
         ST_PREV_RD: prev_rd_en = prev_more;
         ST_CURR_RD: begin
            curr_rd_en = curr_more;
            i_inc      = !curr_more;
         end
         ST_CMP: begin
            j_inc      = id_gt;
            i_inc      = !id_gt && !id_eq;
            emit_match = !id_gt && id_eq && out_free;
         end
         ST_SQ_X:    sq_first = 1'b1;
         ST_SQ_Y:    sq_second = 1'b1;
         ST_ROOT:    root_step = 1'b1;
         ST_ACC: begin
            acc_en = 1'b1;
            i_inc  = 1'b1;
         end
         ST_PROD:    prod_en = 1'b1;
         ST_SUMMARY: emit_summary = out_free;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   // config register
   always_ff @(posedge clock) begin
      if (reset) min_radius_ff <= '0;
      else if (csr_valid && csr_ready) min_radius_ff <= csr_data;
   end

   // table writes
   always_ff @(posedge clock) begin
      if (load_prev) prev_mem[prev_fill_ff[AW-1:0]] <= req_tdata[ENTRY_W-1:0] == '0 ?
         '0 : {req_tdata[ID_W-1:0], req_tdata[ID_W +: COORD_W],
               req_tdata[ID_W+COORD_W +: COORD_W]};
      if (load_curr) curr_mem[curr_fill_ff[AW-1:0]] <=
         {req_tdata[ID_W-1:0], req_tdata[ID_W +: COORD_W],
          req_tdata[ID_W+COORD_W +: COORD_W]};
   end

   // table reads, registered
   always_ff @(posedge clock) begin
      if (prev_rd_en) prev_rd_ff <= prev_mem[i_ff[AW-1:0]];
      if (curr_rd_en) curr_rd_ff <= curr_mem[j_ff[AW-1:0]];
   end

   // fill counts, cleared when the summary leaves
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_fill_ff <= '0;
         curr_fill_ff <= '0;
      end else if (emit_summary) begin
         prev_fill_ff <= '0;
         curr_fill_ff <= '0;
      end else begin
         if (load_prev) prev_fill_ff <= CW'(prev_fill_ff + 1'b1);
         if (load_curr) curr_fill_ff <= CW'(curr_fill_ff + 1'b1);
      end
   end

   // scan indexes
   always_ff @(posedge clock) begin
      if (run_start) i_ff <= '0;
      else if (i_inc) i_ff <= CW'(i_ff + 1'b1);
      if (prev_rd_en) j_ff <= '0;
      else if (j_inc) j_ff <= CW'(j_ff + 1'b1);
   end

   // coordinate differences and magnitudes
   assign dx = (COORD_W+1)'(signed'(prev_rd_ff[2*COORD_W-1:COORD_W])) -
               (COORD_W+1)'(signed'(curr_rd_ff[2*COORD_W-1:COORD_W]));
   assign dy = (COORD_W+1)'(signed'(prev_rd_ff[COORD_W-1:0])) -
               (COORD_W+1)'(signed'(curr_rd_ff[COORD_W-1:0]));
   assign abs_dx = dx[COORD_W] ? MUL_W'(-dx) : MUL_W'(dx);
   assign abs_dy = dy[COORD_W] ? MUL_W'(-dy) : MUL_W'(dy);

   // shared multiplier
   always_comb begin
      mul_a = abs_dx;
      mul_b = abs_dx;
      if (sq_second) begin
         mul_a = abs_dy;
         mul_b = abs_dy;
      end else if (prod_en) begin
         mul_a = min_radius_ff;
         mul_b = MUL_W'(count_ff);
      end
   end
   assign mul_p  = mul_a * mul_b;
   assign sq_sum = sq_ff + SQ_W'(mul_p);

   // square root step, two radicand bits per cycle
   assign rem_shift = {rem_ff[REM_W-3:0], rad_ff[RAD_W-1 -: 2]};
   assign trial     = {root_ff, 2'b01};
   assign trial_ok  = (rem_shift >= trial);
   assign root_inc  = (ROOT_W+1)'(root_ff) + 1'b1;

   always_ff @(posedge clock) begin
      if (sq_first) sq_ff <= SQ_W'(mul_p);
      if (sq_second) begin
         rad_ff  <= {sq_sum, 2'b00};
         rem_ff  <= '0;
         root_ff <= '0;
         step_ff <= '0;
      end else if (root_step) begin
         rad_ff  <= {rad_ff[RAD_W-3:0], 2'b00};
         rem_ff  <= trial_ok ? REM_W'(rem_shift - trial) : rem_shift;
         root_ff <= {root_ff[ROOT_W-2:0], trial_ok};
         step_ff <= STEP_W'(step_ff + 1'b1);
      end
      if (prod_en) prod_ff <= mul_p;
   end

   // distance sum and match count
   always_ff @(posedge clock) begin
      if (run_start) begin
         sum_ff   <= '0;
         count_ff <= '0;
      end else if (acc_en) begin
         sum_ff   <= SUM_W'(sum_ff + SUM_W'(root_inc[ROOT_W:1]));
         count_ff <= CW'(count_ff + 1'b1);
      end
   end

   assign skip = (PROD_W'(sum_ff) < prod_ff);

   // output register
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (emit_match || emit_summary) rsp_valid_ff <= 1'b1;
      else if (rsp_tready) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (emit_match) begin
         rsp_data_ff <= RSP_DATA_W'({IDX_W'(j_ff), IDX_W'(i_ff)});
         rsp_user_ff <= 1'b1;
         rsp_last_ff <= 1'b0;
      end else if (emit_summary) begin
         rsp_data_ff <= RSP_DATA_W'({skip, IDX_W'(count_ff), {2*IDX_W{1'b0}}});
         rsp_user_ff <= 1'b0;
         rsp_last_ff <= 1'b1;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

@@ bench/testbench.sv @@
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import tmmg_pkg::*;

   localparam int MAX_PTS     = MAX_POINTS_DEF;
   localparam int ITEM_GOAL   = 460;
   localparam int CYCLE_LIMIT = 3000000;
   localparam int DRAIN_WAIT  = 40;
   localparam int IDLE_WAIT   = 8;

   // one table entry: id, x, y
   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
   } point_type;

   // one result word as predicted
   typedef struct packed {
      logic             is_match;
      logic [IDX_W-1:0] prev_slot;
      logic [IDX_W-1:0] curr_slot;
      logic [IDX_W-1:0] count;
      logic             skip;
      logic             last;
   } gate_rsp_type;

   // directed stimulus row; summary fields typed in where obvious
   typedef struct {
      action_type         act;
      logic [ID_W-1:0]    id;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      bit                 typed;
      logic [IDX_W-1:0]   t_count;
      bit                 t_skip;
   } dir_row_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_DATA_W-1:0] csr_data;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [REQ_USER_W-1:0] req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;

   // predictor state
   point_type         prev_pts [MAX_PTS];
   point_type         curr_pts [MAX_PTS];
   int                prev_fill;
   int                curr_fill;
   logic [15:0]       min_radius;
   gate_rsp_type      pending_rsp [$];
   int                pushed_total;

   // bookkeeping
   int     cycle;
   int     errors;
   int     items_sent;
   int     runs_sent;
   int     csr_writes;
   int     matches_seen;
   int     summaries_seen;
   int     skips_seen;
   bit     steady;
   int     rsp_hold;
   gate_rsp_type want_w;

   dir_row_type dir_rows [0:19] = '{
      '{ACT_RUN,       32'h0000_0000, 16'h0000, 16'h0000, 1'b1, 6'd0, 1'b0},
      '{ACT_NONE,      32'hFFFF_FFFF, 16'h7FFF, 16'h8000, 1'b0, 6'd0, 1'b0},
      '{ACT_LOAD_PREV, 32'h0000_0000, 16'h8000, 16'h8000, 1'b0, 6'd0, 1'b0},
      '{ACT_LOAD_PREV, 32'h0000_0005, 16'h0000, 16'h0000, 1'b0, 6'd0, 1'b0},
      '{ACT_LOAD_PREV, 32'hFFFF_FFFF, 16'h7FFF, 16'h7FFF, 1'b0, 6'd0, 1'b0},
      '{ACT_LOAD_CURR, 32'h0000_0000, 16'h7FFF, 16'h7FFF, 1'b0, 6'd0, 1'b0},
      '{ACT_LOAD_CURR, 32'h0000_0003, 16'h0001, 16'hFFFF, 1'b0, 6'd0, 1'b0},
      '{ACT_LOAD_CURR, 32'h0000_0007, 16'h0010, 16'h0020, 1'b0, 6'd0, 1'b0},
      '{ACT_LOAD_CURR, 32'hFFFF_FFFF, 16'h8000, 16'h7FFF, 1'b0, 6'd0, 1'b0},
      '{ACT_RUN,       32'h1234_5678, 16'hABCD, 16'h5432, 1'b0, 6'd0, 1'b0},
      '{ACT_LOAD_PREV, 32'h0000_000A, 16'h0100, 16'h0100, 1'b0, 6'd0, 1'b0},
      '{ACT_LOAD_CURR, 32'h0000_000B, 16'h0100, 16'h0100, 1'b0, 6'd0, 1'b0},
      '{ACT_RUN,       32'h0000_0000, 16'h0000, 16'h0000, 1'b1, 6'd0, 1'b0},
      '{ACT_LOAD_PREV, 32'h0000_0001, 16'h0000, 16'h0000, 1'b0, 6'd0, 1'b0},
      '{ACT_LOAD_CURR, 32'h0000_0001, 16'h0000, 16'h0000, 1'b0, 6'd0, 1'b0},
      '{ACT_RUN,       32'h0000_0000, 16'h0000, 16'h0000, 1'b0, 6'd0, 1'b0},
      '{ACT_LOAD_PREV, 32'h8000_0002, 16'hFFF0, 16'h0030, 1'b0, 6'd0, 1'b0},
      '{ACT_LOAD_PREV, 32'h8000_0002, 16'h0005, 16'hFFFB, 1'b0, 6'd0, 1'b0},
      '{ACT_LOAD_CURR, 32'h8000_0002, 16'h0000, 16'h0000, 1'b0, 6'd0, 1'b0},
      '{ACT_RUN,       32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b0, 6'd0, 1'b0}
   };

   track_match_motion_gate u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // cycle count and timeout
   always @(posedge clock) begin
      cycle++;
      if (cycle > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words still expected", cycle,
                  pending_rsp.size());
         $display("track_match_motion_gate verification failed");
         $finish;
      end
   end

   // gap length: mostly none or short, sometimes long
   function automatic int pick_gap();
      int r;
      if (steady)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // floor square root by setting one result bit at a time
   function automatic longint unsigned root_floor(longint unsigned v);
      longint unsigned r;
      longint unsigned t;
      r = 0;
      for (int b = 19; b >= 0; b--) begin
         t = r | (64'd1 << b);
         if (t * t <= v)
            r = t;
      end
      return r;
   endfunction

   // euclidean distance as an unsigned integer, rounded to nearest
   function automatic longint unsigned pair_dist(point_type a, point_type b);
      longint          dx;
      longint          dy;
      longint unsigned sq;
      dx = longint'($signed(a.x)) - longint'($signed(b.x));
      dy = longint'($signed(a.y)) - longint'($signed(b.y));
      sq = dx * dx + dy * dy;
      return (root_floor(4 * sq) + 1) >> 1;
   endfunction

   // update table state and queue the words a request word causes
   task automatic predict_word(action_type act, point_type pt);
      int              count;
      longint unsigned sum;
      gate_rsp_type    w;
      count = 0;
      sum   = 0;
      case (act)
         ACT_LOAD_PREV: begin
            if (prev_fill < MAX_PTS) begin
               prev_pts[prev_fill] = pt;
               prev_fill++;
            end
         end
         ACT_LOAD_CURR: begin
            if (curr_fill < MAX_PTS) begin
               curr_pts[curr_fill] = pt;
               curr_fill++;
            end
         end
         ACT_RUN: begin
            // first current id not below each previous id; match only on equal
            for (int i = 0; i < prev_fill; i++) begin
               for (int j = 0; j < curr_fill; j++) begin
                  if (prev_pts[i].id > curr_pts[j].id)
                     continue;
                  if (prev_pts[i].id == curr_pts[j].id) begin
                     w = '{1'b1, IDX_W'(i), IDX_W'(j), 6'd0, 1'b0, 1'b0};
                     pending_rsp.insert(pending_rsp.size(), w);
                     pushed_total++;
                     sum += pair_dist(prev_pts[i], curr_pts[j]);
                     count++;
                  end
                  break;
               end
            end
            w = '{1'b0, 6'd0, 6'd0, IDX_W'(count),
                  (sum < longint'(min_radius) * count), 1'b1};
            pending_rsp.insert(pending_rsp.size(), w);
            pushed_total++;
            prev_fill = 0;
            curr_fill = 0;
            runs_sent++;
         end
         default: ;
      endcase
   endtask

   // drive one request word, wait for acceptance, then predict it
   task automatic send_word(action_type act, point_type pt);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tuser  <= act;
      req_tdata  <= {pt.y, pt.x, pt.id};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      predict_word(act, pt);
      if (act != ACT_NONE)
         items_sent++;
      @(negedge clock);
   endtask

   // let the block drain before a register write
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0)
         @(negedge clock);
      repeat (IDLE_WAIT) @(negedge clock);
   endtask

   task automatic write_radius(logic [15:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      min_radius = value;
      csr_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic report_mismatch(string what);
      errors++;
      if (errors <= 40)
         $display("mismatch at cycle %0d: %s", cycle, what);
   endtask

   task automatic check_field(string name, longint got, longint want);
      if (got != want)
         report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
   endtask

   // result ready with random stalls
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold--;
      end else begin
         rsp_tready <= 1'b1;
         if (!steady && $urandom_range(0, 3) == 0)
            rsp_hold = pick_gap();
      end
   end

   // compare each accepted result word with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("result word with nothing expected");
         end else begin
            want_w = pending_rsp.pop_front();
            check_field("is_match", rsp_tuser, want_w.is_match);
            check_field("prev_index", rsp_tdata[5:0], want_w.prev_slot);
            check_field("curr_index", rsp_tdata[11:6], want_w.curr_slot);
            check_field("match_count", rsp_tdata[17:12], want_w.count);
            check_field("skip", rsp_tdata[18], want_w.skip);
            check_field("pad", rsp_tdata[23:19], 0);
            check_field("last", rsp_tlast, want_w.last);
            if (want_w.is_match) begin
               matches_seen++;
            end else begin
               summaries_seen++;
               if (want_w.skip)
                  skips_seen++;
            end
         end
      end
   end

   // one table pair and a run; mostly sorted ids with nearby positions
   task automatic run_frame();
      int          kind;
      int          pool_n;
      int          sel;
      int          pi;
      int          ci;
      logic [31:0] id_cur;
      point_type   prev_q [$];
      point_type   curr_q [$];
      point_type   p;
      point_type   c;
      point_type   junk;
      logic [15:0] dx;
      logic [15:0] dy;
      kind   = $urandom_range(0, 9);
      steady = ($urandom_range(0, 4) == 0);
      if (kind == 9)
         pool_n = $urandom_range(0, 2);
      else if ($urandom_range(0, 7) == 0)
         pool_n = $urandom_range(20, 40);
      else
         pool_n = $urandom_range(1, 12);
      id_cur = $urandom;
      for (int k = 0; k < pool_n; k++) begin
         id_cur += $urandom_range(1, 5000);
         p.id = (kind == 8) ? 32'($urandom) : id_cur;
         p.x  = 16'($urandom);
         p.y  = 16'($urandom);
         sel  = $urandom_range(0, 3);
         if (sel != 1)
            prev_q.insert(prev_q.size(), p);
         if (sel != 0) begin
            c = p;
            if (kind < 7) begin
               dx  = 16'($urandom_range(0, 200) - 100);
               dy  = 16'($urandom_range(0, 200) - 100);
               c.x = p.x + dx;
               c.y = p.y + dy;
            end else begin
               c.x = 16'($urandom);
               c.y = 16'($urandom);
            end
            curr_q.insert(curr_q.size(), c);
         end
      end
      // interleave both tables, each in its own order, with some noise
      pi = 0;
      ci = 0;
      while (pi < prev_q.size() || ci < curr_q.size()) begin
         junk = {32'($urandom), 16'($urandom), 16'($urandom)};
         if ($urandom_range(0, 24) == 0)
            send_word(ACT_NONE, junk);
         if (ci >= curr_q.size() || (pi < prev_q.size() && $urandom_range(0, 1) == 0)) begin
            send_word(ACT_LOAD_PREV, prev_q[pi]);
            pi++;
         end else begin
            send_word(ACT_LOAD_CURR, curr_q[ci]);
            ci++;
         end
      end
      junk = {32'($urandom), 16'($urandom), 16'($urandom)};
      send_word(ACT_RUN, junk);
   endtask

   initial begin
      int           mark;
      point_type    pt;
      gate_rsp_type typed_w;
      clock      = 1'b0;
      reset      = 1'b1;
      csr_valid  = 1'b0;
      csr_data   = '0;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = ACT_NONE;
      rsp_tready = 1'b0;
      rsp_hold   = 0;
      steady     = 1'b0;
      prev_fill  = 0;
      curr_fill  = 0;
      min_radius = '0;
      pushed_total = 0;
      cycle      = 0;
      errors     = 0;
      items_sent = 0;
      runs_sent  = 0;
      csr_writes = 0;
      matches_seen   = 0;
      summaries_seen = 0;
      skips_seen     = 0;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table
      write_radius(16'hFFFF);
      foreach (dir_rows[r]) begin
         pt = {dir_rows[r].id, dir_rows[r].x, dir_rows[r].y};
         mark = pushed_total;
         send_word(dir_rows[r].act, pt);
         if (dir_rows[r].typed) begin
            // replace this row's predicted words by the typed summary
            repeat (pushed_total - mark)
               void'(pending_rsp.pop_back());
            typed_w = '{1'b0, 6'd0, 6'd0, dir_rows[r].t_count,
                        dir_rows[r].t_skip, 1'b1};
            pending_rsp.insert(pending_rsp.size(), typed_w);
         end
      end
      wait_idle();
      write_radius(16'h0000);

      // random frames, register changed now and then while idle
      while (items_sent < ITEM_GOAL) begin
         if ($urandom_range(0, 2) == 0) begin
            wait_idle();
            case ($urandom_range(0, 5))
               0:       write_radius(16'h0000);
               1:       write_radius(16'hFFFF);
               2:       write_radius(16'($urandom));
               default: write_radius(16'($urandom_range(0, 160)));
            endcase
         end
         run_frame();
      end

      // drain
      steady = 1'b0;
      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("sent %0d table and run words over %0d runs, %0d register writes",
               items_sent, runs_sent, csr_writes);
      $display("checked %0d match words and %0d summaries (%0d with skip set)",
               matches_seen, summaries_seen, skips_seen);
      if (errors == 0) begin
         $display("track_match_motion_gate verification clean");
      end else begin
         $display("%0d mismatches", errors);
         $display("track_match_motion_gate verification failed");
      end
      $finish;
   end

endmodule
